### rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ECR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ecr assertion failed");
// property whose consequence must hold in the cycle after the antecedent
`define ECR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecr assertion failed");
`else
`define ECR_ASSERT_ALWAYS(label, expr)
`define ECR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/ecr_pkg.sv
// types and codes of the elevator call register
`default_nettype none
package ecr_pkg;

    localparam int unsigned MAP_COUNT = 8;
    localparam int unsigned FLOOR_COUNT = 32;

    // item kinds
    localparam logic [2:0] KIND_EVENT   = 3'd0;
    localparam logic [2:0] KIND_SETMODE = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_ARRIVAL = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;

    // bitmap modes
    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_LASTONE = 3'd1;
    localparam logic [2:0] MODE_CONHOLD = 3'd2;
    localparam logic [2:0] MODE_TOGGLE  = 3'd3;
    localparam logic [2:0] MODE_FROZEN  = 3'd4;
    localparam logic [2:0] MODE_KILL    = 3'd5;

    // travel directions
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // call types
    localparam logic [1:0] TYPE_CAR    = 2'd0;
    localparam logic [1:0] TYPE_CAR2   = 2'd1;
    localparam logic [1:0] TYPE_HALLUP = 2'd2;
    localparam logic [1:0] TYPE_HALLDN = 2'd3;

    // register address of side_enable
    localparam logic [1:0] ADDR_SIDE_ENABLE = 2'd0;

    typedef struct packed {
        logic [2:0] kind;
        logic       side;
        logic [1:0] call_type;
        logic [4:0] floor;
        logic       level;
        logic [2:0] new_mode;
        logic [1:0] direction;
    } ecr_item_t;

    typedef struct packed {
        logic [3:0] here_mask;
        logic [3:0] above_mask;
        logic [3:0] under_mask;
    } ecr_result_t;

    // all bitmaps and modes, index = side * 4 + call type
    typedef struct packed {
        logic [MAP_COUNT-1:0][FLOOR_COUNT-1:0] bits;
        logic [MAP_COUNT-1:0][2:0]             mode;
    } ecr_state_t;

endpackage
`default_nettype wire

### rtl/ecr_step.sv
// next-state and report logic for one item
`default_nettype none
module ecr_step #(
    parameter logic [31:0] VALID_FLOORS = 32'hFFFF_FFFF
) (
    input  wire ecr_pkg::ecr_item_t  item,
    input  wire ecr_pkg::ecr_state_t state,
    input  wire logic [1:0]          side_enable,
    output ecr_pkg::ecr_state_t  state_next,
    output ecr_pkg::ecr_result_t result
);
    import ecr_pkg::*;

    logic [31:0] floor_bit;
    logic [31:0] above_sel;
    logic [31:0] under_sel;
    logic [2:0]  idx;
    logic [2:0]  cur_mode;
    logic [2:0]  side_mode;
    logic [2:0]  base;

    always_comb
    begin
        floor_bit = (32'd1 << item.floor) & VALID_FLOORS;
        above_sel = VALID_FLOORS & ~((32'd2 << item.floor) - 32'd1);
        under_sel = VALID_FLOORS & ((32'd1 << item.floor) - 32'd1);
        idx       = {item.side, item.call_type};
        cur_mode  = state.mode[idx];
        base      = {item.side, 2'b00};
        side_mode = MODE_KILL;
        state_next = state;

        unique case (item.kind)
            KIND_EVENT:
            begin
                if (cur_mode < MODE_KILL)
                begin
                    if (item.level)
                    begin
                        if (cur_mode == MODE_LASTONE || cur_mode == MODE_CONHOLD)
                            state_next.bits[idx] = '0;
                        else if (cur_mode == MODE_TOGGLE)
                            state_next.bits[idx] = state.bits[idx] ^ floor_bit;
                        else
                            state_next.bits[idx] = state.bits[idx] | floor_bit;
                    end
                    else if (cur_mode == MODE_CONHOLD)
                    begin
                        state_next.bits[idx] = '0;
                    end
                end
            end
            KIND_SETMODE:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    side_mode = side_enable[s] ? item.new_mode : MODE_KILL;
                    state_next.mode[{1'(s), item.call_type}] = side_mode;
                    if (side_mode > MODE_FROZEN)
                        state_next.bits[{1'(s), item.call_type}] = '0;
                end
            end
            KIND_CLEAR:
            begin
                state_next.bits[{1'b0, item.call_type}] = '0;
                state_next.bits[{1'b1, item.call_type}] = '0;
            end
            KIND_ARRIVAL:
            begin
                state_next.bits[base | 3'(TYPE_CAR)] =
                    state.bits[base | 3'(TYPE_CAR)] & ~floor_bit;
                state_next.bits[base | 3'(TYPE_CAR2)] =
                    state.bits[base | 3'(TYPE_CAR2)] & ~floor_bit;
                if (item.direction != DIR_UP)
                    state_next.bits[base | 3'(TYPE_HALLDN)] =
                        state.bits[base | 3'(TYPE_HALLDN)] & ~floor_bit;
                if (item.direction != DIR_DOWN)
                    state_next.bits[base | 3'(TYPE_HALLUP)] =
                        state.bits[base | 3'(TYPE_HALLUP)] & ~floor_bit;
            end
            default:
            begin
                // query only, unused kinds too
            end
        endcase

        // report from the updated bitmaps, frozen ones stay silent
        result = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (state_next.mode[i] != MODE_FROZEN)
            begin
                if (1'(i >> 2) == item.side && (state_next.bits[i] & floor_bit) != '0)
                    result.here_mask[i % 4] = 1'b1;
                if ((state_next.bits[i] & above_sel) != '0)
                    result.above_mask[i % 4] = 1'b1;
                if ((state_next.bits[i] & under_sel) != '0)
                    result.under_mask[i % 4] = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/elevator_call_register.sv
// top level of the elevator call register
// an item taken into the input register gives its result beat from the result register (done high one cycle)
// throughput: one item per cycle, busy stays low; one input register, one result register
// the rate is set by the single update-and-report stage over the eight bitmaps
// reset (rst_n low, asynchronous): bitmaps empty, all modes normal, side_enable = 3
// results cannot be stalled: each beat is shown for exactly one cycle
`default_nettype none
`include "assert_macros.svh"
module elevator_call_register #(
    parameter int GROUP_COUNT = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [1:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // item beat
    input  wire logic                 start,
    output logic                      busy,
    input  wire ecr_pkg::ecr_item_t   item,
    // result beat
    output logic                      done,
    output ecr_pkg::ecr_result_t      result
);
    import ecr_pkg::*;

    // groups of eight floors beyond four find no room in the 32-bit bitmaps
    localparam int VALID_GROUPS = (GROUP_COUNT > 4) ? 4 : GROUP_COUNT;
    localparam logic [31:0] VALID_FLOORS = (VALID_GROUPS >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * VALID_GROUPS)) - 64'd1);

    logic [1:0]  side_enable_reg;
    ecr_state_t  state_reg;
    ecr_state_t  state_next;
    ecr_item_t   item_reg;
    logic        stage_valid_reg;
    ecr_result_t result_reg;
    ecr_result_t result_next;
    logic        done_reg;
    logic        cfg_write;
    logic        killed_nonempty;

    // the block never holds off an item
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // apb write completes in the access phase
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SIDE_ENABLE)
            prdata = {30'd0, side_enable_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_enable_reg <= 2'b11;
        else if (cfg_write && paddr == ADDR_SIDE_ENABLE)
            side_enable_reg <= pwdata[1:0];
    end

    // input register: one item per cycle
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= start & ~busy;
    end

    // update the bitmaps and form the report in one pass
    ecr_step #(
        .VALID_FLOORS (VALID_FLOORS)
    ) u_step (
        .item        (item_reg),
        .state       (state_reg),
        .side_enable (side_enable_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // call state, written only when an item is in the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (stage_valid_reg)
            state_reg <= state_next;
    end

    // result register and strobe
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage_valid_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a kill or unused mode always leaves its bitmap empty
    always_comb
    begin
        killed_nonempty = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (state_reg.mode[i] > MODE_FROZEN && state_reg.bits[i] != '0)
                killed_nonempty = 1'b1;
        end
    end

    `ECR_ASSERT_NEXT(a_done_follows_item, stage_valid_reg, done)
    `ECR_ASSERT_NEXT(a_no_spurious_done, !stage_valid_reg, !done)
    `ECR_ASSERT_ALWAYS(a_killed_map_empty, !killed_nonempty)
    `ECR_ASSERT_ALWAYS(a_no_call_beyond_top, (state_reg.bits[0] & ~VALID_FLOORS) == '0)

endmodule
`default_nettype wire

### sim/tb_top.sv
// testbench for the elevator call register: directed and random call traffic checked against a predictor
module tb_top;
    import ecr_pkg::*;

    // the block is built with four floor groups, so all 32 floors are served
    localparam int GROUP_COUNT = 4;
    // wait allowance for the result beat after the accepting edge
    localparam int RESULT_LATENCY = 2;
    // cycles with no beat of any kind before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // mismatches printed in full, the rest only counted
    localparam int REPORT_LIMIT = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_BOTH = 2'd3;
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam logic SIDE_FRONT = 1'b0;
    localparam logic SIDE_REAR = 1'b1;
    localparam logic LEVEL_RELEASED = 1'b0;
    localparam logic LEVEL_PRESSED = 1'b1;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic start;
    logic busy;
    ecr_item_t item;
    logic done;
    ecr_result_t result;

    // predictor state: one floor bitmap and one mode per side and call type
    logic [31:0] floor_calls [8];
    logic [2:0] map_mode [8];
    logic [1:0] enabled_sides;

    // reports still owed by the block, oldest first
    ecr_result_t pending_reports [$];
    int fail_count;
    int stall_cycles;

    elevator_call_register #(
        .GROUP_COUNT(GROUP_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floors that belong to a configured group
    function automatic logic [31:0] served_floors();
        if (GROUP_COUNT >= 4)
            return 32'hFFFF_FFFF;
        return (32'd1 << (8 * GROUP_COUNT)) - 32'd1;
    endfunction

    // apply one item to the call bitmaps, then report here / above / under
    function automatic ecr_result_t update_and_report(input ecr_item_t it);
        logic [31:0] floors;
        logic [31:0] floor_bit;
        logic [31:0] above;
        logic [31:0] under;
        logic [2:0] idx;
        logic [2:0] stored;
        ecr_result_t rep;
        int s;
        int i;
        floors = served_floors();
        floor_bit = (32'd1 << it.floor) & floors;
        above = floors & ~((32'd2 << it.floor) - 32'd1);
        under = floors & ((32'd1 << it.floor) - 32'd1);
        idx = {it.side, it.call_type};
        case (it.kind)
            KIND_EVENT:
            begin
                // kill and the spare codes above it ignore events
                if (map_mode[idx] < MODE_KILL)
                begin
                    if (it.level == LEVEL_PRESSED)
                    begin
                        if (map_mode[idx] == MODE_LASTONE || map_mode[idx] == MODE_CONHOLD)
                            floor_calls[idx] = '0;
                        else if (map_mode[idx] == MODE_TOGGLE)
                            floor_calls[idx] ^= floor_bit;
                        else
                            floor_calls[idx] |= floor_bit;
                    end
                    else if (map_mode[idx] == MODE_CONHOLD)
                    begin
                        floor_calls[idx] = '0;
                    end
                end
            end
            KIND_SETMODE:
            begin
                // one write reaches both sides; a disabled side is killed
                for (s = 0; s < 2; s++)
                begin
                    stored = enabled_sides[s] ? it.new_mode : MODE_KILL;
                    map_mode[{s[0], it.call_type}] = stored;
                    if (stored > MODE_FROZEN)
                        floor_calls[{s[0], it.call_type}] = '0;
                end
            end
            KIND_CLEAR:
            begin
                floor_calls[{SIDE_FRONT, it.call_type}] = '0;
                floor_calls[{SIDE_REAR, it.call_type}] = '0;
            end
            KIND_ARRIVAL:
            begin
                // hall calls against the travel direction survive the stop
                floor_calls[{it.side, TYPE_CAR}] &= ~floor_bit;
                floor_calls[{it.side, TYPE_CAR2}] &= ~floor_bit;
                if (it.direction != DIR_UP)
                    floor_calls[{it.side, TYPE_HALLDN}] &= ~floor_bit;
                if (it.direction != DIR_DOWN)
                    floor_calls[{it.side, TYPE_HALLUP}] &= ~floor_bit;
            end
            default:
            begin
                // query and the spare kinds change nothing
            end
        endcase
        rep = '0;
        for (i = 0; i < 8; i++)
        begin
            // a frozen bitmap stays silent in every report
            if (map_mode[i] != MODE_FROZEN)
            begin
                if (i[2] == it.side && (floor_calls[i] & floor_bit) != 0)
                    rep.here_mask[i[1:0]] = 1'b1;
                if ((floor_calls[i] & above) != 0)
                    rep.above_mask[i[1:0]] = 1'b1;
                if ((floor_calls[i] & under) != 0)
                    rep.under_mask[i[1:0]] = 1'b1;
            end
        end
        return rep;
    endfunction

    function automatic ecr_item_t make_item(input logic [2:0] kind, input logic side,
                                            input logic [1:0] call_type, input logic [4:0] floor,
                                            input logic level, input logic [2:0] new_mode,
                                            input logic [1:0] direction);
        ecr_item_t it;
        it.kind = kind;
        it.side = side;
        it.call_type = call_type;
        it.floor = floor;
        it.level = level;
        it.new_mode = new_mode;
        it.direction = direction;
        return it;
    endfunction

    // random traffic: mostly events, queries and arrivals, few mode changes
    function automatic ecr_item_t make_random_item();
        logic [31:0] raw;
        ecr_item_t it;
        int pick;
        raw = $urandom;
        it = raw[$bits(ecr_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.kind = KIND_EVENT;
        else if (pick < 60)
            it.kind = KIND_QUERY;
        else if (pick < 75)
            it.kind = KIND_ARRIVAL;
        else if (pick < 83)
            it.kind = KIND_SETMODE;
        else if (pick < 88)
            it.kind = KIND_CLEAR;
        else
            it.kind = 3'($urandom_range(KIND_SPARE5, KIND_SPARE7));
        // live modes most of the time so the bitmaps keep filling up
        if ($urandom_range(0, 9) < 7)
            it.new_mode = 3'($urandom_range(MODE_NORMAL, MODE_TOGGLE));
        else
            it.new_mode = 3'($urandom_range(MODE_FROZEN, MODE_SPARE7));
        it.level = ($urandom_range(0, 9) < 7) ? LEVEL_PRESSED : LEVEL_RELEASED;
        // a few busy floors so arrivals and toggles hit set bits
        if ($urandom_range(0, 1) == 0)
            it.floor = 5'($urandom_range(0, 3) * 10 + 1);
        return it;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", what);
    endtask

    // drive one item beat and hold it until the block takes it; start stays high
    task automatic send_item(input ecr_item_t it);
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        pending_reports.push_back(update_and_report(it));
    endtask

    task automatic idle_sender(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // stop sending and let every owed report come back
    task automatic wait_for_reports();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 1) @(posedge clk);
    endtask

    // write side_enable over the register port, then read it back
    task automatic write_side_enable(input logic [1:0] value);
        wait_for_reports();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SIDE_ENABLE;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        enabled_sides = value;
        // straight into the setup cycle of the read
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(value))
            note_failure($sformatf("side_enable readback: expected %h, got %h",
                                   32'(value), prdata));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // every kind, every mode, the field extremes and the odd codes
    task automatic test_directed_calls();
        send_item(make_item(KIND_QUERY, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_REAR, TYPE_HALLDN, 5'd31, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_BOTH));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_HALLUP, 5'd16, LEVEL_PRESSED,
                            MODE_SPARE7, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR2, 5'd9, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_QUERY, SIDE_FRONT, TYPE_CAR, 5'd16, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        // release in normal mode leaves the bitmap alone
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR, 5'd3, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        // toggle clears a set floor and sets an empty one
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_RELEASED,
                            MODE_TOGGLE, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_REAR, TYPE_CAR, 5'd20, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        // last one: a press wipes the whole bitmap
        send_item(make_item(KIND_SETMODE, SIDE_REAR, TYPE_CAR2, 5'd0, LEVEL_RELEASED,
                            MODE_LASTONE, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR2, 5'd2, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        // continuous hold: a release wipes the whole bitmap
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_HALLUP, 5'd0, LEVEL_RELEASED,
                            MODE_CONHOLD, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_HALLUP, 5'd4, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        // frozen keeps taking calls but reports none of them
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_HALLDN, 5'd0, LEVEL_RELEASED,
                            MODE_FROZEN, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_REAR, TYPE_HALLDN, 5'd10, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_QUERY, SIDE_REAR, TYPE_CAR, 5'd10, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_HALLDN, 5'd0, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        // arrivals: going up keeps hall down, going down clears it, odd code clears both
        send_item(make_item(KIND_ARRIVAL, SIDE_REAR, TYPE_CAR, 5'd10, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_UP));
        send_item(make_item(KIND_ARRIVAL, SIDE_REAR, TYPE_CAR, 5'd10, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_DOWN));
        send_item(make_item(KIND_ARRIVAL, SIDE_REAR, TYPE_CAR, 5'd20, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_BOTH));
        send_item(make_item(KIND_CLEAR, SIDE_FRONT, TYPE_HALLDN, 5'd31, LEVEL_RELEASED,
                            MODE_NORMAL, DIR_NONE));
        // kill and a spare mode both wipe the bitmap and then ignore events
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_CAR2, 5'd0, LEVEL_RELEASED,
                            MODE_SPARE6, DIR_NONE));
        send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_RELEASED,
                            MODE_KILL, DIR_NONE));
        send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR, 5'd1, LEVEL_PRESSED,
                            MODE_NORMAL, DIR_NONE));
        send_item(make_item(KIND_SPARE7, SIDE_REAR, TYPE_HALLDN, 5'd31, LEVEL_PRESSED,
                            MODE_SPARE7, DIR_BOTH));
    endtask

    // a disabled side takes kill on every mode write
    task automatic test_side_enable();
        logic [1:0] setting;
        int n;
        for (n = 0; n < 4; n++)
        begin
            setting = 2'(n + 1);
            write_side_enable(setting);
            send_item(make_item(KIND_SETMODE, SIDE_FRONT, TYPE_CAR, 5'd0, LEVEL_RELEASED,
                                MODE_NORMAL, DIR_NONE));
            send_item(make_item(KIND_EVENT, SIDE_FRONT, TYPE_CAR, 5'd7, LEVEL_PRESSED,
                                MODE_NORMAL, DIR_NONE));
            send_item(make_item(KIND_EVENT, SIDE_REAR, TYPE_CAR, 5'd25, LEVEL_PRESSED,
                                MODE_NORMAL, DIR_NONE));
            send_item(make_item(KIND_QUERY, SIDE_REAR, TYPE_CAR, 5'd25, LEVEL_RELEASED,
                                MODE_NORMAL, DIR_NONE));
        end
    endtask

    // random traffic after setting every call type to normal mode on the enabled sides
    task automatic test_random_traffic(input int count, input int idle_pct);
        int t;
        int n;
        for (t = 0; t < 4; t++)
            send_item(make_item(KIND_SETMODE, SIDE_FRONT, 2'(t), 5'd0, LEVEL_RELEASED,
                                MODE_NORMAL, DIR_NONE));
        for (n = 0; n < count; n++)
        begin
            idle_sender(idle_pct);
            send_item(make_random_item());
            // halfway through, hold off until the block has caught up
            if (n == count / 2)
                wait_for_reports();
        end
    endtask

    // every result beat is checked against the oldest owed report
    always @(posedge clk)
    begin : report_check
        ecr_result_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                note_failure($sformatf("result beat with nothing owed: %h", result));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result.here_mask !== want.here_mask
                    || result.above_mask !== want.above_mask
                    || result.under_mask !== want.under_mask)
                    note_failure($sformatf({"result mismatch: expected here %h above %h ",
                                            "under %h, got here %h above %h under %h"},
                                           want.here_mask, want.above_mask, want.under_mask,
                                           result.here_mask, result.above_mask,
                                           result.under_mask));
            end
        end
    end

    // hang guard: any accepted beat on any port restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        item = '0;
        fail_count = 0;
        stall_cycles = 0;
        for (i = 0; i < 8; i++)
        begin
            floor_calls[i] = '0;
            map_mode[i] = MODE_NORMAL;
        end
        enabled_sides = 2'b11;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_calls();
        test_side_enable();
        // several side settings, the extremes among them, across the idle phases
        write_side_enable(2'b11);
        test_random_traffic(420, 0);
        write_side_enable(2'b01);
        test_random_traffic(260, 76);
        write_side_enable(2'b10);
        test_random_traffic(260, 27);
        write_side_enable(2'b00);
        test_random_traffic(60, 0);
        write_side_enable(2'b11);
        test_random_traffic(380, 27);

        wait_for_reports();
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        if (pending_reports.size() != 0)
            note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ecr_pkg.sv
rtl/ecr_step.sv
rtl/elevator_call_register.sv
sim/tb_top.sv
